// ----- rtl/core/ctsb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsb_pkg
// Shared types and codes for the clipped transparent stamp blitter.
// ----------------------------------------------------------------------------
package ctsb_pkg;

    // Command codes carried on the input tuser field
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_APPLY = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CANVAS_HEIGHT    = 2'd0,
        CFG_CANVAS_WIDTH     = 2'd1,
        CFG_TRANSPARENT_CODE = 2'd2,
        CFG_BLANK_CODE       = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_WALK,
        ST_DRAIN,
        ST_FETCH,
        ST_DONE
    } state_t;

    localparam logic [7:0] RESET_CODE  = 8'd46;
    localparam logic [6:0] RESET_SIZE  = 7'd64;

endpackage

// ----- rtl/core/ctsb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsb_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module ctsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/clipped_transparent_stamp_blit_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_transparent_stamp_blit_core
// Character-cell blitter: canvas and stamp stores, clipped transparent apply.
// ----------------------------------------------------------------------------
// Load: EXEC writes the stamp cell, then DONE; read: EXEC, FETCH, DONE, with FETCH skipped
// when out of range. Apply: EXEC, WALK, DRAIN, DONE (straight to DONE when nothing is
// walked), one stamp cell per cycle through the stamp read port and one canvas write port.
// Clear: one canvas cell per cycle. One command at a time; the next word is taken in the
// cycle after the result enters the output register. After reset a clearing pass fills the
// canvas with 46 before the first word is taken; configuration writes are always taken.
module clipped_transparent_stamp_blit_core #(
    parameter int CANVAS_ROWS = 64,
    parameter int CANVAS_COLS = 64,
    parameter int STAMP_ROWS  = 32,
    parameter int STAMP_COLS  = 32,
    parameter int STAMP_SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // tdata: slot[2:0], cell_row[8:3], cell_col[14:9], cell_value[22:15],
    // stamp_height[28:23], stamp_width[34:29], place_row[41:35], place_col[48:42]
    input  logic [55:0] s_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: read_value[7:0], out_of_range[8]
    output logic [15:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int RW  = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;
    localparam int CW  = (CANVAS_COLS > 1) ? $clog2(CANVAS_COLS) : 1;
    localparam int SRB = (STAMP_ROWS > 1) ? $clog2(STAMP_ROWS) : 1;
    localparam int SCB = (STAMP_COLS > 1) ? $clog2(STAMP_COLS) : 1;
    localparam int SSB = (STAMP_SLOTS > 1) ? $clog2(STAMP_SLOTS) : 1;
    localparam int CA  = RW + CW;
    localparam int SA  = SSB + SRB + SCB;
    localparam int CANVAS_DEPTH = 1 << CA;
    localparam int STAMP_DEPTH  = 1 << SA;

    localparam logic [8:0] CROWS_LIM = 9'(CANVAS_ROWS);
    localparam logic [8:0] CCOLS_LIM = 9'(CANVAS_COLS);
    localparam logic [8:0] SROWS_LIM = 9'(STAMP_ROWS);
    localparam logic [8:0] SCOLS_LIM = 9'(STAMP_COLS);
    localparam logic [6:0] SLOTS_LIM = 7'(STAMP_SLOTS);

    // Input field slices
    logic [2:0] in_slot;
    logic [5:0] in_row;
    logic [5:0] in_col;
    logic [7:0] in_value;
    logic [5:0] in_sh;
    logic [5:0] in_sw;
    logic [6:0] in_prow;
    logic [6:0] in_pcol;

    assign in_slot  = s_tdata[2:0];
    assign in_row   = s_tdata[8:3];
    assign in_col   = s_tdata[14:9];
    assign in_value = s_tdata[22:15];
    assign in_sh    = s_tdata[28:23];
    assign in_sw    = s_tdata[34:29];
    assign in_prow  = s_tdata[41:35];
    assign in_pcol  = s_tdata[48:42];

    ctsb_pkg::state_t state_reg, state_next;

    logic [6:0] canvas_height_reg;
    logic [6:0] canvas_width_reg;
    logic [7:0] transparent_reg;
    logic [7:0] blank_reg;

    ctsb_pkg::cmd_t cmd_reg;
    logic [2:0]     slot_reg;
    logic [5:0]     row_reg;
    logic [5:0]     col_reg;
    logic [7:0]     value_reg;
    logic [6:0]     prow_reg;
    logic [6:0]     pcol_reg;
    logic [SRB-1:0] sh_last_reg;
    logic [SCB-1:0] sw_last_reg;
    logic           walk_ok_reg;

    logic [SRB-1:0] r_reg, r_next;
    logic [SCB-1:0] c_reg, c_next;
    logic [CA-1:0]  fill_reg, fill_next;
    logic           wr_pend_reg, wr_pend_next;
    logic [CA-1:0]  wr_addr_reg, wr_addr_next;

    logic [7:0] rd_reg, rd_next;
    logic       oor_reg, oor_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_rd_reg;
    logic       m_oor_reg;

    // Memory controls
    logic          canvas_we;
    logic [CA-1:0] canvas_waddr;
    logic [7:0]    canvas_wdata;
    logic [CA-1:0] canvas_raddr;
    logic [7:0]    canvas_rdata;
    logic          stamp_we;
    logic [SA-1:0] stamp_waddr;
    logic [SA-1:0] stamp_raddr;
    logic [7:0]    stamp_rdata;

    // Effective canvas size
    logic [8:0] ch, cw;
    assign ch = ({2'b00, canvas_height_reg} > CROWS_LIM) ? CROWS_LIM : {2'b00, canvas_height_reg};
    assign cw = ({2'b00, canvas_width_reg} > CCOLS_LIM) ? CCOLS_LIM : {2'b00, canvas_width_reg};

    // Stamp size at accept time, saturated to the store
    logic [8:0] sh_eff, sw_eff, sh_dec, sw_dec;
    assign sh_eff = ({3'b000, in_sh} > SROWS_LIM) ? SROWS_LIM : {3'b000, in_sh};
    assign sw_eff = ({3'b000, in_sw} > SCOLS_LIM) ? SCOLS_LIM : {3'b000, in_sw};
    assign sh_dec = sh_eff - 9'd1;
    assign sw_dec = sw_eff - 9'd1;

    // Addresses of the latched command
    logic [8:0] row9, col9;
    logic [5:0] slot6;
    assign row9  = {3'b000, row_reg};
    assign col9  = {3'b000, col_reg};
    assign slot6 = {3'b000, slot_reg};

    logic load_ok, read_ok;
    assign load_ok = ({4'b0000, slot_reg} < SLOTS_LIM) && (row9 < SROWS_LIM)
                     && (col9 < SCOLS_LIM);
    assign read_ok = (row9 < ch) && (col9 < cw);

    // Clip unit: destination of the stamp cell under the walk counters
    logic [8:0]        r9, c9;
    logic [9:0]        dr, dc;
    logic              dest_ok;
    assign r9 = {{(9-SRB){1'b0}}, r_reg};
    assign c9 = {{(9-SCB){1'b0}}, c_reg};
    assign dr = {{3{prow_reg[6]}}, prow_reg} + {1'b0, r9};
    assign dc = {{3{pcol_reg[6]}}, pcol_reg} + {1'b0, c9};
    assign dest_ok = !dr[9] && (dr[8:0] < ch) && !dc[9] && (dc[8:0] < cw);

    logic walk_last;
    assign walk_last = (r_reg == sh_last_reg) && (c_reg == sw_last_reg);

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    assign s_tready  = (state_reg == ctsb_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {7'd0, m_oor_reg, m_rd_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ctsb_pkg::ST_INIT:
            begin
                if (&fill_reg)
                begin
                    state_next = ctsb_pkg::ST_IDLE;
                end
            end
            ctsb_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ctsb_pkg::ST_EXEC;
                end
            end
            ctsb_pkg::ST_EXEC:
            begin
                unique case (cmd_reg)
                    ctsb_pkg::CMD_CLEAR: state_next = ctsb_pkg::ST_FILL;
                    ctsb_pkg::CMD_LOAD:  state_next = ctsb_pkg::ST_DONE;
                    ctsb_pkg::CMD_APPLY:
                        state_next = walk_ok_reg ? ctsb_pkg::ST_WALK : ctsb_pkg::ST_DONE;
                    ctsb_pkg::CMD_READ:
                        state_next = read_ok ? ctsb_pkg::ST_FETCH : ctsb_pkg::ST_DONE;
                    default:             state_next = ctsb_pkg::ST_DONE;
                endcase
            end
            ctsb_pkg::ST_FILL:
            begin
                if (&fill_reg)
                begin
                    state_next = ctsb_pkg::ST_DONE;
                end
            end
            ctsb_pkg::ST_WALK:
            begin
                if (walk_last)
                begin
                    state_next = ctsb_pkg::ST_DRAIN;
                end
            end
            ctsb_pkg::ST_DRAIN: state_next = ctsb_pkg::ST_DONE;
            ctsb_pkg::ST_FETCH: state_next = ctsb_pkg::ST_DONE;
            ctsb_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ctsb_pkg::ST_IDLE;
                end
            end
            default: state_next = ctsb_pkg::ST_IDLE;
        endcase
    end

    // Memory controls
    always_comb
    begin
        canvas_we    = 1'b0;
        canvas_waddr = wr_addr_reg;
        canvas_wdata = stamp_rdata;
        stamp_we     = 1'b0;
        unique case (state_reg)
            ctsb_pkg::ST_INIT:
            begin
                canvas_we    = 1'b1;
                canvas_waddr = fill_reg;
                canvas_wdata = ctsb_pkg::RESET_CODE;
            end
            ctsb_pkg::ST_FILL:
            begin
                canvas_we    = 1'b1;
                canvas_waddr = fill_reg;
                canvas_wdata = blank_reg;
            end
            ctsb_pkg::ST_EXEC:
            begin
                stamp_we = (cmd_reg == ctsb_pkg::CMD_LOAD) && load_ok;
            end
            ctsb_pkg::ST_WALK, ctsb_pkg::ST_DRAIN:
            begin
                // The stamp cell fetched last cycle lands now unless clipped or transparent
                canvas_we = wr_pend_reg && (stamp_rdata != transparent_reg);
            end
            default:
            begin
                canvas_we = 1'b0;
            end
        endcase
    end

    assign canvas_raddr = {row9[RW-1:0], col9[CW-1:0]};
    assign stamp_waddr  = {slot6[SSB-1:0], row9[SRB-1:0], col9[SCB-1:0]};
    assign stamp_raddr  = {slot6[SSB-1:0], r_reg, c_reg};

    // Datapath next values
    always_comb
    begin
        r_next        = r_reg;
        c_next        = c_reg;
        fill_next     = fill_reg;
        wr_pend_next  = 1'b0;
        wr_addr_next  = wr_addr_reg;
        rd_next       = rd_reg;
        oor_next      = oor_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        case (state_reg)
            ctsb_pkg::ST_INIT, ctsb_pkg::ST_FILL:
            begin
                fill_next = fill_reg + CA'(1);
            end
            ctsb_pkg::ST_EXEC:
            begin
                rd_next   = 8'd0;
                oor_next  = ((cmd_reg == ctsb_pkg::CMD_LOAD) && !load_ok)
                            || ((cmd_reg == ctsb_pkg::CMD_READ) && !read_ok);
                r_next    = '0;
                c_next    = '0;
                fill_next = '0;
            end
            ctsb_pkg::ST_WALK:
            begin
                wr_pend_next = dest_ok;
                wr_addr_next = {dr[RW-1:0], dc[CW-1:0]};
                if (c_reg == sw_last_reg)
                begin
                    c_next = '0;
                    r_next = r_reg + SRB'(1);
                end
                else
                begin
                    c_next = c_reg + SCB'(1);
                end
            end
            ctsb_pkg::ST_FETCH:
            begin
                rd_next = canvas_rdata;
            end
            ctsb_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                end
            end
            default:
            begin
                wr_pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ctsb_pkg::ST_INIT;
            canvas_height_reg <= ctsb_pkg::RESET_SIZE;
            canvas_width_reg  <= ctsb_pkg::RESET_SIZE;
            transparent_reg   <= ctsb_pkg::RESET_CODE;
            blank_reg         <= ctsb_pkg::RESET_CODE;
            fill_reg          <= '0;
            r_reg             <= '0;
            c_reg             <= '0;
            wr_pend_reg       <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            wr_pend_reg  <= wr_pend_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid)
            begin
                unique case (ctsb_pkg::cfg_idx_t'(cfg_index))
                    ctsb_pkg::CFG_CANVAS_HEIGHT:    canvas_height_reg <= cfg_data[6:0];
                    ctsb_pkg::CFG_CANVAS_WIDTH:     canvas_width_reg  <= cfg_data[6:0];
                    ctsb_pkg::CFG_TRANSPARENT_CODE: transparent_reg   <= cfg_data;
                    ctsb_pkg::CFG_BLANK_CODE:       blank_reg         <= cfg_data;
                    default:                        blank_reg         <= blank_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        wr_addr_reg <= wr_addr_next;
        rd_reg      <= rd_next;
        oor_reg     <= oor_next;
        // The output word is held here so that the next command can run meanwhile.
        if ((state_reg == ctsb_pkg::ST_DONE) && out_free)
        begin
            m_rd_reg  <= rd_reg;
            m_oor_reg <= oor_reg;
        end
        if (s_tvalid && s_tready)
        begin
            cmd_reg     <= ctsb_pkg::cmd_t'(s_tuser);
            slot_reg    <= in_slot;
            row_reg     <= in_row;
            col_reg     <= in_col;
            value_reg   <= in_value;
            prow_reg    <= in_prow;
            pcol_reg    <= in_pcol;
            sh_last_reg <= sh_dec[SRB-1:0];
            sw_last_reg <= sw_dec[SCB-1:0];
            walk_ok_reg <= ({1'b0, in_slot} < SLOTS_LIM[3:0] || STAMP_SLOTS > 8)
                           && (sh_eff != 9'd0) && (sw_eff != 9'd0);
        end
    end

    ctsb_ram #(
        .WIDTH (8),
        .DEPTH (CANVAS_DEPTH)
    ) u_canvas (
        .clk   (clk),
        .we    (canvas_we),
        .waddr (canvas_waddr),
        .wdata (canvas_wdata),
        .raddr (canvas_raddr),
        .rdata (canvas_rdata)
    );

    ctsb_ram #(
        .WIDTH (8),
        .DEPTH (STAMP_DEPTH)
    ) u_stamp (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (stamp_waddr),
        .wdata (value_reg),
        .raddr (stamp_raddr),
        .rdata (stamp_rdata)
    );

endmodule
